@@ rtl/clp_pkg.sv @@
package clp_pkg;

	// Parser phases, one-hot
	typedef enum logic [8:0] {
		PH_LEAD = 9'b000000001,
		PH_MNEM = 9'b000000010,
		PH_PING = 9'b000000100,
		PH_SP1  = 9'b000001000,
		PH_NUM1 = 9'b000010000,
		PH_SP2  = 9'b000100000,
		PH_NUM2 = 9'b001000000,
		PH_DONE = 9'b010000000,
		PH_FAIL = 9'b100000000
	} phase_t;

	typedef enum logic [3:0] {
		K_ERR  = 4'd0,
		K_PING = 4'd1,
		K_AIN  = 4'd2,
		K_AOUT = 4'd3,
		K_DIN  = 4'd4,
		K_DOUT = 4'd5,
		K_DIR  = 4'd6,
		K_LED  = 4'd7,
		K_SW   = 4'd8,
		K_REL  = 4'd9
	} kind_t;

	// Mnemonic groups by first letter
	localparam logic [2:0] G_P    = 3'd0;
	localparam logic [2:0] G_A    = 3'd1;
	localparam logic [2:0] G_D    = 3'd2;
	localparam logic [2:0] G_L    = 3'd3;
	localparam logic [2:0] G_S    = 3'd4;
	localparam logic [2:0] G_R    = 3'd5;
	localparam logic [2:0] G_NONE = 3'd7;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [12:0] NUM_SAT = 13'd8191;
	localparam logic [12:0] DAC_MAX = 13'd4095;

	// Line parse state seen by the command check
	typedef struct packed {
		phase_t      phase;
		logic [4:0]  prog;
		logic [12:0] first;
		logic [12:0] second;
	} line_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  chan;
		logic [11:0] value;
	} result_t;

	function automatic logic [2:0] group_of(input logic [7:0] c);
		logic [2:0] g;
		case (c)
			"P":     g = G_P;
			"A":     g = G_A;
			"D":     g = G_D;
			"L":     g = G_L;
			"S":     g = G_S;
			"R":     g = G_R;
			default: g = G_NONE;
		endcase
		return g;
	endfunction

	function automatic logic [7:0] ping_char(input logic [1:0] m);
		logic [7:0] c;
		case (m)
			2'd0:    c = "P";
			2'd1:    c = "I";
			2'd2:    c = "N";
			default: c = "G";
		endcase
		return c;
	endfunction

	function automatic logic takes_two(input logic [4:0] k);
		return k == 5'(K_AOUT) || k == 5'(K_DOUT) || k == 5'(K_DIR) ||
			k == 5'(K_LED) || k == 5'(K_REL);
	endfunction

	// acc * 10 + digit, saturated
	function automatic logic [12:0] accumulate(input logic [12:0] acc, input logic [3:0] d);
		logic [16:0] n;
		n = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {13'd0, d};
		return (n > {4'd0, NUM_SAT}) ? NUM_SAT : n[12:0];
	endfunction

endpackage

@@ rtl/clp_parser.sv @@
module clp_parser #(
	parameter int LineBytes = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output clp_pkg::line_state_t line_state
);
	import clp_pkg::*;

	localparam int CW = $clog2(LineBytes);
	localparam logic [CW:0] KEEP_LIMIT = (CW + 1)'(LineBytes - 1);

	logic [CW-1:0] count_q;
	logic          ended_q;
	phase_t        phase_q, phase_d;
	logic [4:0]    prog_q, prog_d;
	logic [12:0]   first_q, first_d;
	logic [12:0]   second_q, second_d;

	logic          is_dig;
	logic [3:0]    digit;
	logic [2:0]    grp;
	logic [1:0]    mcnt;
	kind_t         mk;
	logic          partial;
	logic          keep;

	assign is_dig = (rx_byte >= CH_0) && (rx_byte <= CH_9);
	assign digit  = 4'(rx_byte - CH_0);
	assign grp    = prog_q[4:2];
	assign mcnt   = prog_q[1:0];
	assign keep   = {1'b0, count_q} < KEEP_LIMIT;

	// Mnemonic letter match
	always_comb begin
		mk      = K_ERR;
		partial = 1'b0;
		case (grp)
			G_P: begin
				if (rx_byte == ping_char(mcnt)) partial = 1'b1;
			end
			G_A: begin
				if (rx_byte == "I") mk = K_AIN;
				else if (rx_byte == "O") mk = K_AOUT;
			end
			G_D: begin
				if (rx_byte == "I") mk = K_DIN;
				else if (rx_byte == "O") mk = K_DOUT;
				else if (rx_byte == "M") mk = K_DIR;
			end
			G_L: begin
				if (mcnt == 2'd1 && rx_byte == "E") partial = 1'b1;
				else if (mcnt == 2'd2 && rx_byte == "D") mk = K_LED;
			end
			G_S: begin
				if (rx_byte == "W") mk = K_SW;
			end
			G_R: begin
				if (mcnt == 2'd1 && rx_byte == "E") partial = 1'b1;
				else if (mcnt == 2'd2 && rx_byte == "L") mk = K_REL;
			end
			default: ;
		endcase
	end

	// Next parse state for one kept character
	always_comb begin
		phase_d  = phase_q;
		prog_d   = prog_q;
		first_d  = first_q;
		second_d = second_q;
		case (phase_q)
			PH_LEAD: begin
				if (rx_byte != CH_SPACE) begin
					if (group_of(rx_byte) == G_NONE) begin
						phase_d = PH_FAIL;
					end else begin
						prog_d  = {group_of(rx_byte), 2'd1};
						phase_d = PH_MNEM;
					end
				end
			end
			PH_MNEM: begin
				if (partial) begin
					if (grp == G_P && mcnt == 2'd3) phase_d = PH_PING;
					else prog_d = {grp, mcnt + 2'd1};
				end else if (mk == K_ERR) begin
					phase_d = PH_FAIL;
				end else begin
					prog_d  = {1'b0, mk};
					phase_d = PH_SP1;
				end
			end
			PH_PING: phase_d = PH_FAIL;
			PH_SP1: begin
				if (rx_byte != CH_SPACE) begin
					if (is_dig) begin
						first_d = {9'd0, digit};
						phase_d = PH_NUM1;
					end else begin
						phase_d = PH_FAIL;
					end
				end
			end
			PH_NUM1: begin
				if (is_dig) first_d = accumulate(first_q, digit);
				else if (!takes_two(prog_q)) phase_d = PH_DONE;
				else phase_d = (rx_byte == CH_SPACE) ? PH_SP2 : PH_FAIL;
			end
			PH_SP2: begin
				if (rx_byte != CH_SPACE) begin
					if (is_dig) begin
						second_d = {9'd0, digit};
						phase_d  = PH_NUM2;
					end else begin
						phase_d = PH_FAIL;
					end
				end
			end
			PH_NUM2: begin
				if (is_dig) second_d = accumulate(second_q, digit);
				else phase_d = PH_DONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ended_q  <= 1'b0;
			phase_q  <= PH_LEAD;
			prog_q   <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else if (step && rx_byte != CH_CR) begin
			if (rx_byte == CH_NL) begin
				// line done: clear for the next one
				count_q  <= '0;
				ended_q  <= 1'b0;
				phase_q  <= PH_LEAD;
				prog_q   <= '0;
				first_q  <= '0;
				second_q <= '0;
			end else if (keep) begin
				count_q <= count_q + 1'b1;
				if (!ended_q) begin
					if (rx_byte == CH_NUL) begin
						ended_q <= 1'b1;
					end else begin
						phase_q  <= phase_d;
						prog_q   <= prog_d;
						first_q  <= first_d;
						second_q <= second_d;
					end
				end
			end
		end
	end

	assign line_state.phase  = phase_q;
	assign line_state.prog   = prog_q;
	assign line_state.first  = first_q;
	assign line_state.second = second_q;

endmodule

@@ rtl/clp_finish.sv @@
module clp_finish (
	input  clp_pkg::line_state_t line_state,
	output clp_pkg::result_t     result
);
	import clp_pkg::*;

	logic [12:0] a, b;
	logic        complete;
	logic        pin_ok;

	assign a      = line_state.first;
	assign b      = line_state.second;
	assign pin_ok = (a >= 13'd2) && (a <= 13'd9);

	always_comb begin
		complete = (line_state.phase == PH_DONE) || (line_state.phase == PH_NUM2) ||
			(line_state.phase == PH_NUM1 && !takes_two(line_state.prog));
		result.kind  = K_ERR;
		result.chan  = 3'd0;
		result.value = 12'd0;
		if (line_state.phase == PH_PING) begin
			result.kind = K_PING;
		end else if (complete) begin
			case (line_state.prog)
				5'(K_AIN): begin
					if (a <= 13'd7) begin
						result.kind = K_AIN;
						result.chan = a[2:0];
					end
				end
				5'(K_AOUT): begin
					if (a <= 13'd3 && b <= DAC_MAX) begin
						result.kind  = K_AOUT;
						result.chan  = a[2:0];
						result.value = b[11:0];
					end
				end
				5'(K_DIN): begin
					if (pin_ok) begin
						result.kind = K_DIN;
						result.chan = a[2:0] - 3'd2;
					end
				end
				5'(K_DOUT), 5'(K_DIR): begin
					if (pin_ok && b <= 13'd1) begin
						result.kind  = kind_t'(line_state.prog[3:0]);
						result.chan  = a[2:0] - 3'd2;
						result.value = b[11:0];
					end
				end
				5'(K_LED): begin
					if (a < 13'd3 && b <= 13'd1) begin
						result.kind  = K_LED;
						result.chan  = a[2:0];
						result.value = b[11:0];
					end
				end
				5'(K_SW): begin
					if (a < 13'd4) begin
						result.kind = K_SW;
						result.chan = a[2:0];
					end
				end
				5'(K_REL): begin
					if (a < 13'd2 && b <= 13'd1) begin
						result.kind  = K_REL;
						result.chan  = a[2:0];
						result.value = b[11:0];
					end
				end
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/ascii_io_command_line_parser.sv @@
// ASCII command line decoder.
// Slave stream: one received character per request in s_tdata[7:0]. Carriage
// returns are dropped, a newline closes the line, a zero byte ends the text.
// Master stream: one decoded command per newline, nothing for other bytes.
// m_tdata carries command kind, channel index and set value.
// Path: an accepted newline is registered in the input stage, then decoded
// and registered in the output register, which drives m_tvalid.
// Throughput: one character per cycle unless the output stalls; the line
// state updates in a single pass from the input register.
// Stall: while a command waits on m_tready the input stage holds one more
// character; s_tready drops only when both the input stage and the output
// register are full and the output is not being taken.
// Reset: arst_n clears the line state, both valid flags and the character
// count; the first byte after reset starts a fresh line.
// LineBytes sets the line length: the first LineBytes-1 characters count.
module ascii_io_command_line_parser #(
	parameter int LineBytes = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [3:0] command_kind, [6:4] channel_index,
	                               // [18:7] set_value, [23:19] zero
);
	import clp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	result_t     result_q;
	logic        advance;
	logic        step;
	line_state_t line_state;
	result_t     fin;

	// advance the input stage whenever the output register is free or drains
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	clp_parser #(
		.LineBytes(LineBytes)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.line_state(line_state)
	);

	// check the finished line against the state before the newline clears it
	clp_finish u_finish (
		.line_state(line_state),
		.result    (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && (byte_s1 == CH_NL);
		end
	end

	always_ff @(posedge clk) begin
		if (step && byte_s1 == CH_NL) result_q <= fin;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, result_q.value, result_q.chan, result_q.kind};

endmodule

@@ verif/command_decode_checker.sv @@
module command_decode_checker #(
	parameter int LineBytes = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	output int          mismatches,
	output int          pending
);
	import clp_pkg::*;

	localparam logic [31:0] PING_WORD = "PING";

	// Line decode state, tracked independently of the block
	int          kept_bytes;
	logic        text_ended;
	phase_t      phase;
	logic [4:0]  progress;
	logic [12:0] num_a;
	logic [12:0] num_b;
	result_t     expected_cmds[$];

	function automatic logic [2:0] letter_group(input logic [7:0] c);
		logic [2:0] g;
		g = G_NONE;
		if (c == "P") g = G_P;
		if (c == "A") g = G_A;
		if (c == "D") g = G_D;
		if (c == "L") g = G_L;
		if (c == "S") g = G_S;
		if (c == "R") g = G_R;
		return g;
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic [12:0] shift_in_digit(input logic [12:0] acc, input logic [7:0] c);
		int n;
		n = int'(acc) * 10 + int'(c - CH_0);
		return (n > int'(NUM_SAT)) ? NUM_SAT : 13'(n);
	endfunction

	function automatic logic wants_value(input logic [4:0] k);
		return k == 5'(K_AOUT) || k == 5'(K_DOUT) || k == 5'(K_DIR) ||
			k == 5'(K_LED) || k == 5'(K_REL);
	endfunction

	task automatic restart_line();
		kept_bytes = 0;
		text_ended = 1'b0;
		phase      = PH_LEAD;
		progress   = 5'd0;
		num_a      = 13'd0;
		num_b      = 13'd0;
	endtask

	task automatic match_mnemonic_letter(input logic [7:0] c);
		logic [2:0] g;
		logic [2:0] m;
		kind_t      k;
		g = progress[4:2];
		m = {1'b0, progress[1:0]};
		k = K_ERR;
		case (g)
			G_P: begin
				if (c == PING_WORD[31 - 8 * m -: 8]) begin
					if (m == 3'd3) phase = PH_PING;
					else progress = {g, 2'(m + 3'd1)};
					return;
				end
			end
			G_A: begin
				if (c == "I") k = K_AIN;
				else if (c == "O") k = K_AOUT;
			end
			G_D: begin
				if (c == "I") k = K_DIN;
				else if (c == "O") k = K_DOUT;
				else if (c == "M") k = K_DIR;
			end
			G_L: begin
				if (m == 3'd1 && c == "E") begin
					progress = {g, 2'd2};
					return;
				end
				if (m == 3'd2 && c == "D") k = K_LED;
			end
			G_S: begin
				if (c == "W") k = K_SW;
			end
			G_R: begin
				if (m == 3'd1 && c == "E") begin
					progress = {g, 2'd2};
					return;
				end
				if (m == 3'd2 && c == "L") k = K_REL;
			end
			default: ;
		endcase
		if (k == K_ERR) begin
			phase = PH_FAIL;
		end else begin
			progress = 5'(k);
			phase    = PH_SP1;
		end
	endtask

	task automatic feed_parser(input logic [7:0] c);
		case (phase)
			PH_LEAD: begin
				if (c != CH_SPACE) begin
					if (letter_group(c) == G_NONE) begin
						phase = PH_FAIL;
					end else begin
						progress = {letter_group(c), 2'd1};
						phase    = PH_MNEM;
					end
				end
			end
			PH_MNEM: match_mnemonic_letter(c);
			PH_PING: phase = PH_FAIL;
			PH_SP1: begin
				if (is_numeral(c)) begin
					num_a = 13'(c - CH_0);
					phase = PH_NUM1;
				end else if (c != CH_SPACE) begin
					phase = PH_FAIL;
				end
			end
			PH_NUM1: begin
				if (is_numeral(c)) num_a = shift_in_digit(num_a, c);
				else if (!wants_value(progress)) phase = PH_DONE;
				else phase = (c == CH_SPACE) ? PH_SP2 : PH_FAIL;
			end
			PH_SP2: begin
				if (is_numeral(c)) begin
					num_b = 13'(c - CH_0);
					phase = PH_NUM2;
				end else if (c != CH_SPACE) begin
					phase = PH_FAIL;
				end
			end
			PH_NUM2: begin
				if (is_numeral(c)) num_b = shift_in_digit(num_b, c);
				else phase = PH_DONE;
			end
			default: ;
		endcase
	endtask

	// Range-check the finished line and form the command it yields
	function automatic result_t decode_line();
		result_t r;
		logic    complete;
		r.kind  = K_ERR;
		r.chan  = 3'd0;
		r.value = 12'd0;
		complete = phase == PH_DONE || phase == PH_NUM2 ||
			(phase == PH_NUM1 && !wants_value(progress));
		if (phase == PH_PING) begin
			r.kind = K_PING;
		end else if (complete) begin
			case (progress)
				5'(K_AIN): begin
					if (num_a <= 13'd7) begin
						r.kind = K_AIN;
						r.chan = num_a[2:0];
					end
				end
				5'(K_AOUT): begin
					if (num_a <= 13'd3 && num_b <= DAC_MAX) begin
						r.kind  = K_AOUT;
						r.chan  = num_a[2:0];
						r.value = num_b[11:0];
					end
				end
				5'(K_DIN): begin
					if (num_a >= 13'd2 && num_a <= 13'd9) begin
						r.kind = K_DIN;
						r.chan = 3'(num_a - 13'd2);
					end
				end
				5'(K_DOUT), 5'(K_DIR): begin
					if (num_a >= 13'd2 && num_a <= 13'd9 && num_b <= 13'd1) begin
						r.kind  = kind_t'(progress[3:0]);
						r.chan  = 3'(num_a - 13'd2);
						r.value = num_b[11:0];
					end
				end
				5'(K_LED): begin
					if (num_a < 13'd3 && num_b <= 13'd1) begin
						r.kind  = K_LED;
						r.chan  = num_a[2:0];
						r.value = num_b[11:0];
					end
				end
				5'(K_SW): begin
					if (num_a < 13'd4) begin
						r.kind = K_SW;
						r.chan = num_a[2:0];
					end
				end
				5'(K_REL): begin
					if (num_a < 13'd2 && num_b <= 13'd1) begin
						r.kind  = K_REL;
						r.chan  = num_a[2:0];
						r.value = num_b[11:0];
					end
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	task automatic take_rx_char(input logic [7:0] c);
		if (c == CH_NL) begin
			expected_cmds.push_back(decode_line());
			restart_line();
		end else if (c != CH_CR && kept_bytes + 1 < LineBytes) begin
			kept_bytes++;
			if (!text_ended) begin
				if (c == CH_NUL) text_ended = 1'b1;
				else feed_parser(c);
			end
		end
	endtask

	task automatic note_failure(input string what, input result_t want, input logic [23:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected kind %0d chan %0d value %0d, got kind %0d chan %0d value %0d",
				what, want.kind, want.chan, want.value, got[3:0], got[6:4], got[18:7]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			restart_line();
			expected_cmds.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_cmds.size() == 0) begin
					want = '0;
					note_failure("command with none outstanding", want, m_tdata);
				end else begin
					want = expected_cmds.pop_front();
					if (m_tdata[3:0] != 4'(want.kind) || m_tdata[6:4] != want.chan ||
							m_tdata[18:7] != want.value)
						note_failure("command mismatch", want, m_tdata);
				end
			end
			if (s_tvalid && s_tready)
				take_rx_char(s_tdata);
			pending = expected_cmds.size();
		end
	end

endmodule

@@ verif/tb_ascii_io_command_line_parser.sv @@
module tb_ascii_io_command_line_parser;
	import clp_pkg::*;

	localparam int LineBytes   = 64;
	localparam int QuietLimit  = 2000;
	localparam int ByteTarget  = 1900;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	int          mismatches;
	int          pending;

	int quiet_cycles = 0;
	int sent_bytes   = 0;
	bit sender_calm  = 1'b0;
	bit sink_calm    = 1'b0;

	string MNEMONICS[9] = '{"PING", "AI", "AO", "DI", "DO", "DM", "LED", "SW", "REL"};
	bit    TAKES_VALUE[10] = '{0, 0, 1, 0, 1, 1, 1, 0, 1, 0};
	string BAD_WORDS[6] = '{"PIN", "PINGG", "AX", "LEX", "RL", "Q"};
	string TAILS[4] = '{" ON", "x", " 7 7", "#"};

	// Extremes of every command, range edges and the usual syntax errors
	string DIRECTED_LINES[] = '{
		"PING", "   PING", "PING ", "PIG", "AI 0", "AI 7", "AI 8",
		"AO 3 4095", "AO0   0", "AO 4 1", "AO 1 4096", "DI 2", "DI 9", "DI 1",
		"DO 9 1", "DO 5 2", "DM 2 0", "LED 2 1", "LED 3 0", "SW 3", "SW 4",
		"REL 1 1", "REL 2 0", "AI 99999", "AI", "AI x", "DO 3x1", "", "XYZ"
	};

	always #6 clk = ~clk;

	ascii_io_command_line_parser #(.LineBytes(LineBytes)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	command_decode_checker #(.LineBytes(LineBytes)) decode_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Draw a random wait, none during a calm stretch; now and then switch into or out of a calm stretch
	function automatic int pick_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0) calm = !calm;
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	// Offer one character; return at the edge where it is taken.
	// s_tready is sampled at the falling edge, where it is stable.
	task automatic send_char(input logic [7:0] c);
		int gap;
		bit taken;
		gap = pick_wait(sender_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		if (c != CH_CR) sent_bytes++;
	endtask

	task automatic send_line(input string text);
		for (int i = 0; i < text.len(); i++) send_char(text[i]);
		send_char(CH_NL);
	endtask

	// Hold the sender until every decoded command has come out
	task automatic drain_commands();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic string decimal_text(input int typical);
		int v;
		case ($urandom_range(0, 9))
			6: v = $urandom_range(0, 4095);
			7: v = $urandom_range(4094, 4097);
			8: v = $urandom_range(8190, 99999);
			9: return $sformatf("0%0d", $urandom_range(0, typical));
			default: v = $urandom_range(0, typical);
		endcase
		return $sformatf("%0d", v);
	endfunction

	// Mostly well-formed commands with random content, some raw noise lines
	task automatic send_random_line();
		string      text;
		int         word;
		logic [7:0] noise;
		text = "";
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(0, 12)) begin
				noise = 8'($urandom_range(0, 255));
				if (noise != CH_NL) send_char(noise);
			end
			send_char(CH_NL);
			return;
		end
		repeat ($urandom_range(0, 3)) text = {text, " "};
		// push the command toward or past the end of the kept part of the line now and then
		if ($urandom_range(0, 24) == 0)
			repeat ($urandom_range(50, 66)) text = {text, " "};
		word = $urandom_range(0, 9);
		if (word == 9) text = {text, BAD_WORDS[$urandom_range(0, 5)]};
		else text = {text, MNEMONICS[word]};
		if (word == 0) begin
			if ($urandom_range(0, 4) == 0) text = {text, "X"};
		end else begin
			repeat ($urandom_range(0, 2)) text = {text, " "};
			if ($urandom_range(0, 19) != 0) text = {text, decimal_text(10)};
			if (TAKES_VALUE[word] || $urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 9) == 0) text = {text, "x"};
				else text = {text, " "};
				repeat ($urandom_range(0, 2)) text = {text, " "};
				if ($urandom_range(0, 19) != 0)
					text = {text, decimal_text((word == 2) ? 4095 : 1)};
			end
			if ($urandom_range(0, 4) == 0) text = {text, TAILS[$urandom_range(0, 3)]};
		end
		// sprinkle carriage returns and the odd zero byte
		for (int i = 0; i < text.len(); i++) begin
			if ($urandom_range(0, 29) == 0) send_char(CH_CR);
			if ($urandom_range(0, 149) == 0) send_char(CH_NUL);
			send_char(text[i]);
		end
		send_char(CH_NL);
	endtask

	// Sender: reset, directed lines, then random lines
	initial begin
		int lines;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'd0;
		lines = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_LINES[i]) send_line(DIRECTED_LINES[i]);
		send_line("PI\015NG\015");
		send_char(8'hFF);
		send_line("\200 AI 1");
		// zero byte ends the text early
		send_char("A");
		send_char("I");
		send_char("3");
		send_char(CH_NUL);
		send_line(" 4 junk");
		send_char("D");
		send_char("O");
		send_char("4");
		send_char(CH_NUL);
		send_line(" 1");
		// last kept slot holds the final digit, then a line too long to reach its command
		send_line({"                                                          ", "AI 7"});
		send_line({"                                                                      ",
			"PING"});
		drain_commands();

		while (sent_bytes < ByteTarget) begin
			send_random_line();
			lines++;
			if (lines % 60 == 0) drain_commands();
		end
		drain_commands();

		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Receiver: stall a random number of cycles before each command
	initial begin
		int  hold;
		bit  seen;
		m_tready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			hold = pick_wait(sink_calm);
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				seen = m_tvalid;
				@(posedge clk);
			end while (!seen);
		end
	end

	// Watchdog: end the run if neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QuietLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

endmodule

@@ files.f @@
rtl/clp_pkg.sv
rtl/clp_parser.sv
rtl/clp_finish.sv
rtl/ascii_io_command_line_parser.sv
verif/command_decode_checker.sv
verif/tb_ascii_io_command_line_parser.sv
